/* rtl/ssf_pkg.sv */
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared widths, codes, types and saturation helpers for the stick
// snapback suppression filter.
// ----------------------------------------------------------------------------
package ssf_pkg;

	localparam int POS_W = 16;
	localparam int VEL_W = POS_W + 1;
	localparam int VF_W  = POS_W + 2;
	localparam int WT_W  = 17;
	localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] MODE_PASS  = 2'd0;
	localparam logic [1:0] MODE_PRED  = 2'd1;
	localparam logic [1:0] MODE_LP    = 2'd2;
	localparam logic [1:0] MODE_PASS3 = 2'd3;

	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_MODES   = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_GAINS = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_GAINS = 3'd2;
	localparam logic [IDX_W-1:0] REG_RAD_SQ  = 3'd3;
	localparam logic [IDX_W-1:0] REG_VGAIN   = 3'd4;
	localparam logic [IDX_W-1:0] REG_AGAIN   = 3'd5;
	localparam int DATA_W = 48;

	// values common to both lanes for one item
	typedef struct packed {
		logic [WT_W-1:0] d2;
		logic [WT_W-1:0] d6;
		logic [23:0]     vgain;
		logic [23:0]     again;
	} ssf_shared_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [59:0] v);
		logic signed [59:0] hi;
		logic signed [59:0] lo;
		hi = 60'sd32767;
		lo = -60'sd32768;
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[POS_W-1:0];
	endfunction

	function automatic logic signed [VF_W-1:0] sat_vf(input logic signed [59:0] v);
		logic signed [59:0] hi;
		logic signed [59:0] lo;
		hi = 60'sd131071;
		lo = -60'sd131072;
		if (v > hi) begin
			return 18'sh1ffff;
		end else if (v < lo) begin
			return 18'sh20000;
		end
		return v[VF_W-1:0];
	endfunction

endpackage

/* rtl/ssf_if.sv */
// ----------------------------------------------------------------------------
// ssf_if
// Valid/ready channels for stick samples and filtered results.
// ----------------------------------------------------------------------------
interface ssf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_sample;
	logic signed [15:0] y_sample;
	modport source (output valid, output x_sample, output y_sample, input ready);
	modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface ssf_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_filtered;
	logic signed [15:0] y_filtered;
	modport source (output valid, output x_filtered, output y_filtered, input ready);
	modport sink   (input valid, input x_filtered, input y_filtered, output ready);
endinterface

/* rtl/stick_snapback_suppression_filter_top.sv */
// ----------------------------------------------------------------------------
// stick_snapback_suppression_filter_top
// Two-axis stick filter: shared radius unit, one lane per axis, output stage.
// ----------------------------------------------------------------------------
// An accepted sample is first squared and summed over both axes, then a
// bit-serial division gives the radius weight and a multiplier takes its
// cube, before the sample is handed over to the lanes. Each axis lane then
// runs up to 14 steps (10 in low-pass mode), each step one product of the
// lane's multiplier, while pass mode sends the sample straight through; the
// merge stage then loads the output register. A new sample is taken as
// soon as the previous one has left the lanes, even if its result is still
// waiting in the output register.
// Configuration registers are written through write_enable/reg_index/
// write_data and must only change while no sample is being processed.
module stick_snapback_suppression_filter_top import ssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_enable,
	input  logic [IDX_W-1:0]  reg_index,
	input  logic [DATA_W-1:0] write_data,
	ssf_in_if.sink            samples,
	ssf_out_if.source         results
);

	typedef enum logic [1:0] {T_IDLE, T_RAD, T_LANE} tstate_t;

	// configuration registers
	logic [3:0]  modes_q;
	logic [47:0] x_gains_q;
	logic [47:0] y_gains_q;
	logic [15:0] rad_sq_q;
	logic [23:0] vgain_q;
	logic [23:0] again_q;

	tstate_t                 state_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic                    ovalid_q;
	logic signed [POS_W-1:0] xo_q;
	logic signed [POS_W-1:0] yo_q;

	logic                    accept;
	logic                    rad_done;
	logic [WT_W-1:0]         d2;
	logic [WT_W-1:0]         d6;
	logic                    lane_start;
	logic                    x_done;
	logic                    y_done;
	logic signed [POS_W-1:0] x_res;
	logic signed [POS_W-1:0] y_res;
	logic                    load;
	ssf_shared_t             shared;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q   <= '0;
			x_gains_q <= '0;
			y_gains_q <= '0;
			rad_sq_q  <= 16'd10000;
			vgain_q   <= '0;
			again_q   <= '0;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_MODES:   modes_q   <= write_data[3:0];
				REG_X_GAINS: x_gains_q <= write_data[47:0];
				REG_Y_GAINS: y_gains_q <= write_data[47:0];
				REG_RAD_SQ:  rad_sq_q  <= write_data[15:0];
				REG_VGAIN:   vgain_q   <= write_data[23:0];
				REG_AGAIN:   again_q   <= write_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// one sample in flight; output register decouples the result side
	assign samples.ready = (state_q == T_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign lane_start    = (state_q == T_RAD) && rad_done;
	// merge stage: both lanes finished and output register free
	assign load          = (state_q == T_LANE) && x_done && y_done &&
	                       (!ovalid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: if (accept)     state_q <= T_RAD;
				T_RAD:  if (rad_done)   state_q <= T_LANE;
				T_LANE: if (load)       state_q <= T_IDLE;
				default:                state_q <= T_IDLE;
			endcase
			if (load)               ovalid_q <= 1'b1;
			else if (results.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= samples.x_sample;
			y_q <= samples.y_sample;
		end
		if (load) begin
			xo_q <= x_res;
			yo_q <= y_res;
		end
	end

	// squares are taken from the held sample, after the transfer
	ssf_radius u_radius (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (x_q),
		.y      (y_q),
		.rad_sq (rad_sq_q),
		.done   (rad_done),
		.d2     (d2),
		.d6     (d6)
	);

	assign shared.d2    = d2;
	assign shared.d6    = d6;
	assign shared.vgain = vgain_q;
	assign shared.again = again_q;

	ssf_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.mode   (modes_q[1:0]),
		.gains  (x_gains_q),
		.shared (shared),
		.x      (x_q),
		.done   (x_done),
		.res    (x_res)
	);

	ssf_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.mode   (modes_q[3:2]),
		.gains  (y_gains_q),
		.shared (shared),
		.x      (y_q),
		.done   (y_done),
		.res    (y_res)
	);

	assign results.valid      = ovalid_q;
	assign results.x_filtered = xo_q;
	assign results.y_filtered = yo_q;

`ifndef SYNTH
	// the radius unit only finishes for a sample that is waiting on it
	a_rad_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rad_done |-> (state_q == T_RAD))
		else $error("radius result outside radius phase");

	// an accepted sample always starts the radius phase
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == T_RAD))
		else $error("accepted sample did not start");

	// a loaded result is presented on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (results.valid && results.x_filtered == $past(x_res)))
		else $error("merged result not presented");

	// the x lane finishes only in the lane phase
	a_lanes_together: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(x_done) |-> (state_q == T_LANE))
		else $error("lane finished outside lane phase");
`endif

endmodule

/* rtl/ssf_radius.sv */
// ----------------------------------------------------------------------------
// ssf_radius
// Radius weight d2 = min(r2, R<<16) / R by restoring division, then d2 cubed.
// ----------------------------------------------------------------------------
module ssf_radius import ssf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [POS_W-1:0] x,
	input  logic signed [POS_W-1:0] y,
	input  logic [15:0]             rad_sq,
	output logic                    done,
	output logic [WT_W-1:0]         d2,
	output logic [WT_W-1:0]         d6
);

	typedef enum logic [2:0] {R_IDLE, R_SQX, R_SQY, R_DIV, R_D6A, R_D6B} rstate_t;

	rstate_t            state_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [31:0]        acc_q;
	logic [15:0]        rem_q;
	logic [WT_W-1:0]    d2_q;
	logic [WT_W-1:0]    d6_q;
	logic [WT_W-1:0]    tmp_q;
	logic [15:0]        rdiv;
	logic signed [17:0] op_a;
	logic signed [17:0] op_b;
	logic signed [35:0] prod;
	logic [32:0]        r2;
	logic [32:0]        rq;
	logic [17:0]        trial;

	assign rdiv = (rad_sq == 16'd0) ? 16'd1 : rad_sq;
	assign rq   = {1'b0, rdiv, 16'd0};

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			R_SQX: begin
				op_a = 18'(x);
				op_b = 18'(x);
			end
			R_SQY: begin
				op_a = 18'(y);
				op_b = 18'(y);
			end
			R_D6A: begin
				op_a = $signed({1'b0, d2_q});
				op_b = $signed({1'b0, d2_q});
			end
			R_D6B: begin
				op_a = $signed({1'b0, tmp_q});
				op_b = $signed({1'b0, d2_q});
			end
			R_IDLE, R_DIV: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod  = op_a * op_b;
		r2    = {1'b0, acc_q} + {1'b0, prod[31:0]};
		trial = {1'b0, rem_q, acc_q[31]} - {2'b0, rdiv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: if (start) state_q <= R_SQX;
				R_SQX:  state_q <= R_SQY;
				R_SQY: begin
					cnt_q   <= '0;
					state_q <= R_DIV;
				end
				R_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= R_D6A;
				end
				R_D6A:  state_q <= R_D6B;
				R_D6B: begin
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_SQX: acc_q <= prod[31:0];
			R_SQY: begin
				acc_q <= (r2 > rq) ? rq[31:0] : r2[31:0];
				rem_q <= '0;
			end
			R_DIV: begin
				if (!trial[17]) begin
					rem_q <= trial[15:0];
					acc_q <= {acc_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[14:0], acc_q[31]};
					acc_q <= {acc_q[30:0], 1'b0};
				end
				if (cnt_q == 5'd31) d2_q <= (!trial[17]) ? {acc_q[15:0], 1'b1}
				                                          : {acc_q[15:0], 1'b0};
			end
			R_D6A: tmp_q <= prod[32:16];
			R_D6B: d6_q  <= prod[32:16];
			R_IDLE: begin
			end
		endcase
	end

	assign done = done_q;
	assign d2   = d2_q;
	assign d6   = d6_q;

endmodule

/* rtl/ssf_lane.sv */
// ----------------------------------------------------------------------------
// ssf_lane
// One axis of the filter: penalties, weight, predictive or low-pass value
// and the final blend, one product per cycle; pass modes return the sample unchanged.
// ----------------------------------------------------------------------------
module ssf_lane import ssf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              mode,
	input  logic [47:0]             gains,
	input  ssf_shared_t             shared,
	input  logic signed [POS_W-1:0] x,
	output logic                    done,
	output logic signed [POS_W-1:0] res
);

	typedef enum logic [1:0] {L_IDLE, L_RUN, L_DONE} lstate_t;
	typedef enum logic [3:0] {
		SQ_SM, PEN_V_LO, PEN_V_HI, SQ_AC, PEN_A_LO, PEN_A_HI, MIX_A, MIX_B,
		VF_A, VF_LO, VF_HI, PRED, OUT_A, OUT_B
	} step_t;

	lstate_t                 state_q;
	step_t                   step_q;
	logic [1:0]              mode_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [VEL_W-1:0] pvel_q;
	logic signed [VF_W-1:0]  vf_q;
	logic signed [POS_W-1:0] out_q;
	logic signed [POS_W-1:0] res_q;

	logic signed [VEL_W-1:0] cvel_q;
	logic signed [VF_W-1:0]  sm_q;
	logic signed [VF_W-1:0]  ac_q;
	logic [34:0]             m2_q;
	logic [41:0]             plo_q;
	logic [WT_W-1:0]         penv_q;
	logic [WT_W-1:0]         w1_q;
	logic signed [43:0]      t_q;
	logic signed [35:0]      a1_q;
	logic [35:0]             klo_q;
	logic signed [18:0]      oth_q;

	logic [15:0]             decay;
	logic [15:0]             pf;
	logic [15:0]             damp;
	logic [WT_W-1:0]         ndecay;
	logic [WT_W-1:0]         ndamp;
	logic [WT_W-1:0]         nd2;
	logic [WT_W-1:0]         w2;
	logic signed [18:0]      op_a;
	logic signed [24:0]      op_b;
	logic signed [43:0]      prod;
	logic signed [VEL_W-1:0] cv;
	logic signed [VEL_W-1:0] diff;
	logic [59:0]             pen_full;
	logic [WT_W-1:0]         pa;
	logic [WT_W-1:0]         pv;
	logic [17:0]             pen_sum;
	logic [WT_W-1:0]         wpen;
	logic [WT_W-1:0]         w1_n;
	logic signed [59:0]      e_t;
	logic signed [59:0]      e_p;
	logic signed [59:0]      acc;
	logic signed [59:0]      blend;
	logic signed [59:0]      pred;
	logic                    pass;

	assign decay  = gains[15:0];
	assign pf     = gains[31:16];
	assign damp   = gains[47:32];
	assign ndecay = ONE_Q16 - {1'b0, decay};
	assign ndamp  = ONE_Q16 - {1'b0, damp};
	assign nd2    = ONE_Q16 - shared.d2;
	assign w2     = ONE_Q16 - w1_q;
	assign cv     = VEL_W'(x) - VEL_W'(pos_q);
	assign diff   = VEL_W'(pos_q) - VEL_W'(out_q);
	assign pass   = (mode == MODE_PASS) || (mode == MODE_PASS3);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			SQ_SM: begin
				op_a = 19'(sm_q);
				op_b = 25'(sm_q);
			end
			PEN_V_LO: begin
				op_a = $signed({1'b0, m2_q[17:0]});
				op_b = $signed({1'b0, shared.vgain});
			end
			PEN_V_HI: begin
				op_a = $signed({2'b0, m2_q[34:18]});
				op_b = $signed({1'b0, shared.vgain});
			end
			SQ_AC: begin
				op_a = 19'(ac_q);
				op_b = 25'(ac_q);
			end
			PEN_A_LO: begin
				op_a = $signed({1'b0, m2_q[17:0]});
				op_b = $signed({1'b0, shared.again});
			end
			PEN_A_HI: begin
				op_a = $signed({2'b0, m2_q[34:18]});
				op_b = $signed({1'b0, shared.again});
			end
			MIX_A: begin
				if (mode_q == MODE_PRED) begin
					op_a = $signed({2'b0, shared.d2});
					op_b = 25'(cvel_q);
				end else begin
					op_a = 19'(out_q);
					op_b = $signed({9'b0, damp});
				end
			end
			MIX_B: begin
				if (mode_q == MODE_PRED) begin
					op_a = 19'(diff);
					op_b = $signed({9'b0, pf});
				end else begin
					op_a = 19'(x);
					op_b = $signed({8'b0, ndamp});
				end
			end
			VF_A: begin
				op_a = 19'(vf_q);
				op_b = $signed({8'b0, ndecay});
			end
			VF_LO: begin
				op_a = $signed({1'b0, a1_q[17:0]});
				op_b = $signed({8'b0, nd2});
			end
			VF_HI: begin
				op_a = 19'($signed(a1_q[35:18]));
				op_b = $signed({8'b0, nd2});
			end
			PRED: begin
				op_a = 19'(vf_q);
				op_b = $signed({8'b0, ndamp});
			end
			OUT_A: begin
				op_a = 19'(x);
				op_b = $signed({8'b0, w1_q});
			end
			OUT_B: begin
				op_a = oth_q;
				op_b = $signed({8'b0, w2});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod = op_a * op_b;

		// wide square times gain from two partial products
		pen_full = ({19'd0, prod[40:0]} << 18) + {18'd0, plo_q};
		pv = (pen_full[59:26] > 34'(ONE_Q16)) ? ONE_Q16 : pen_full[42:26];
		pa = (pen_full[59:24] > 36'(ONE_Q16)) ? ONE_Q16 : pen_full[40:24];
		pen_sum = {1'b0, penv_q} + {1'b0, pa};
		wpen = (pen_sum > 18'(ONE_Q16)) ? '0 : ONE_Q16 - pen_sum[WT_W-1:0];
		w1_n = (shared.d6 > wpen) ? shared.d6 : wpen;

		e_t   = 60'(t_q);
		e_p   = 60'(prod);
		acc   = (e_t <<< 16) + (e_p <<< 18) + $signed({24'd0, klo_q});
		blend = (e_t + e_p) >>> 16;
		pred  = 60'(out_q) + (e_p >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			step_q  <= SQ_SM;
			mode_q  <= MODE_PASS;
			pos_q   <= '0;
			pvel_q  <= '0;
			vf_q    <= '0;
			out_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				L_IDLE, L_DONE: begin
					if (start) begin
						mode_q <= mode;
						if (pass) begin
							pos_q   <= x;
							pvel_q  <= cv;
							out_q   <= x;
							res_q   <= x;
							state_q <= L_DONE;
						end else begin
							step_q  <= SQ_SM;
							state_q <= L_RUN;
						end
					end
				end
				L_RUN: begin
					if (step_q == VF_HI) vf_q <= sat_vf(acc >>> 32);
					if (step_q == OUT_B) begin
						res_q   <= sat_pos(blend);
						out_q   <= sat_pos(blend);
						pos_q   <= x;
						pvel_q  <= cvel_q;
						state_q <= L_DONE;
					end else if (step_q == MIX_B && mode_q != MODE_PRED) begin
						step_q <= OUT_A;
					end else begin
						step_q <= step_t'(step_q + 4'd1);
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q != L_RUN)) begin
			cvel_q <= cv;
			sm_q   <= VF_W'(cv) + VF_W'(pvel_q);
			ac_q   <= VF_W'(cv) - VF_W'(pvel_q);
		end
		if (state_q == L_RUN) begin
			unique case (step_q)
				SQ_SM, SQ_AC:       m2_q <= prod[34:0];
				PEN_V_LO, PEN_A_LO: plo_q <= prod[41:0];
				PEN_V_HI:           penv_q <= pv;
				PEN_A_HI:           w1_q <= w1_n;
				MIX_A, OUT_A:       t_q <= prod;
				MIX_B: begin
					if (mode_q == MODE_PRED) t_q <= t_q + prod;
					else                     oth_q <= blend[18:0];
				end
				VF_A:  a1_q  <= prod[35:0];
				VF_LO: klo_q <= prod[35:0];
				PRED:  oth_q <= pred[18:0];
				VF_HI, OUT_B: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign done = (state_q == L_DONE);
	assign res  = res_q;

endmodule

/* tb/stick_snapback_suppression_filter_top_tb.sv */
// ----------------------------------------------------------------------------
// stick_snapback_suppression_filter_top_tb
// Self-checking bench for the stick snapback suppression filter. A table of
// directed samples runs first, then phases of random stick trajectories under
// several mode, gain and radius settings. Every result transfer is checked
// against a cycle-free bench predictor, or a directed row's pass-mode value.
// ----------------------------------------------------------------------------
module stick_snapback_suppression_filter_top_tb;
	import ssf_pkg::*;

	localparam longint ONE = 65536;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		bit          typed;
		logic [15:0] ex;
		logic [15:0] ey;
	} sample_row_t;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
	} stick_pair_t;

	logic              clk;
	logic              arst_n;
	logic              write_enable;
	logic [IDX_W-1:0]  reg_index;
	logic [DATA_W-1:0] write_data;

	ssf_in_if  smp ();
	ssf_out_if res ();

	stick_snapback_suppression_filter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.samples      (smp),
		.results      (res)
	);

	// bench copy of the configuration
	logic [3:0]  cfg_modes;
	logic [47:0] cfg_gains [2];
	logic [15:0] cfg_rad_sq;
	logic [23:0] cfg_vgain;
	logic [23:0] cfg_again;

	// bench copy of the per-axis filter state, index 0 is x, 1 is y
	longint last_pos [2];
	longint last_vel [2];
	longint vel_filt [2];
	longint last_out [2];

	stick_pair_t filtered_q [$];
	int          mismatches;
	bit          quiet;       // no random idling on either side
	bit          hold_req;    // asks the receiver for a long hold-off
	int          hold_left;

	sample_row_t directed [20];

	// ------------------------------------------------------------------
	// filter predictor
	// ------------------------------------------------------------------
	function automatic longint sat_w(longint v, int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// capped velocity or acceleration penalty, Q1.16
	function automatic longint unsigned motion_penalty(longint v, longint unsigned g, int sh);
		longint unsigned m;
		longint unsigned m2;
		longint unsigned p;
		m = (v < 0) ? longint'(-v) : longint'(v);
		m2 = m * m;
		if (g == 0) return 0;
		if (m2 > 64'hFFFF_FFFF_FFFF_FFFF / g) return ONE;
		p = (m2 * g) >> sh;
		return (p > ONE) ? ONE : p;
	endfunction

	function automatic longint filter_axis(int ax, logic [1:0] mode, longint x,
			longint d2, longint d6);
		longint decay, pf, damp, vel, smooth, accel, w1, w2, other, acc, o;
		longint unsigned pen;
		decay  = longint'(cfg_gains[ax][15:0]);
		pf     = longint'(cfg_gains[ax][31:16]);
		damp   = longint'(cfg_gains[ax][47:32]);
		vel    = x - last_pos[ax];
		smooth = vel + last_vel[ax];
		accel  = vel - last_vel[ax];
		if (mode == MODE_PRED || mode == MODE_LP) begin
			pen = motion_penalty(smooth, cfg_vgain, 26) + motion_penalty(accel, cfg_again, 24);
			if (pen > ONE) pen = ONE;
			w1 = ONE - longint'(pen);
			if (d6 > w1) w1 = d6;
			w2 = ONE - w1;
			if (mode == MODE_PRED) begin
				acc = (d2 * vel + pf * (last_pos[ax] - last_out[ax])) * ONE
					+ (ONE - decay) * (ONE - d2) * vel_filt[ax];
				vel_filt[ax] = sat_w(acc >>> 32, VF_W);
				other = last_out[ax] + (((ONE - damp) * vel_filt[ax]) >>> 16);
			end else begin
				other = (last_out[ax] * damp + x * (ONE - damp)) >>> 16;
			end
			o = sat_w((w1 * x + w2 * other) >>> 16, POS_W);
		end else begin
			o = x;
		end
		last_pos[ax] = x;
		last_vel[ax] = vel;
		last_out[ax] = o;
		return o;
	endfunction

	function automatic stick_pair_t filter_sample(logic [15:0] xs, logic [15:0] ys);
		longint x, y, d2, d6;
		longint unsigned rq, r2;
		stick_pair_t r;
		x  = longint'($signed(xs));
		y  = longint'($signed(ys));
		rq = longint'((cfg_rad_sq == 0) ? 16'd1 : cfg_rad_sq) << 16;
		r2 = longint'(x * x + y * y);
		if (r2 > rq) r2 = rq;
		d2 = longint'((r2 * ONE) / rq);
		d6 = (((d2 * d2) >> 16) * d2) >> 16;
		r.x = 16'(filter_axis(0, cfg_modes[1:0], x, d2, d6));
		r.y = 16'(filter_axis(1, cfg_modes[3:2], y, d2, d6));
		return r;
	endfunction

	// ------------------------------------------------------------------
	// clock, timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 3_000_000);
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random hold-off, plus one long hold counted here
	// ------------------------------------------------------------------
	initial begin
		res.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
			end
		end
	end

	// result transfers checked against the oldest prediction
	always @(posedge clk) begin
		stick_pair_t e;
		if (arst_n && res.valid && res.ready) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h", res.x_filtered, res.y_filtered);
			end else begin
				e = filtered_q.pop_front();
				if (res.x_filtered !== e.x || res.y_filtered !== e.y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected x=%h y=%h, got x=%h y=%h",
							e.x, e.y, res.x_filtered, res.y_filtered);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= val;
		case (idx)
			REG_MODES:   cfg_modes    = val[3:0];
			REG_X_GAINS: cfg_gains[0] = val[47:0];
			REG_Y_GAINS: cfg_gains[1] = val[47:0];
			REG_RAD_SQ:  cfg_rad_sq   = val[15:0];
			REG_VGAIN:   cfg_vgain    = val[23:0];
			REG_AGAIN:   cfg_again    = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop offering, wait for the block to drain, then load a full setting
	task automatic configure(logic [3:0] modes, logic [47:0] xg, logic [47:0] yg,
			logic [15:0] rad, logic [23:0] vg, logic [23:0] ag);
		@(negedge clk);
		smp.valid <= 1'b0;
		wait (filtered_q.size() == 0);
		repeat (70) @(posedge clk);
		write_reg(REG_MODES, modes);
		write_reg(REG_X_GAINS, xg);
		write_reg(REG_Y_GAINS, yg);
		write_reg(REG_RAD_SQ, rad);
		write_reg(REG_VGAIN, vg);
		write_reg(REG_AGAIN, ag);
		@(negedge clk);
		write_enable <= 1'b0;
	endtask

	// one sample transfer; a typed expectation replaces the prediction
	task automatic send_sample(logic [15:0] xs, logic [15:0] ys, bit typed,
			logic [15:0] ex, logic [15:0] ey);
		stick_pair_t p;
		if (!quiet && $urandom_range(99) < 26) begin
			@(negedge clk);
			smp.valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		smp.valid    <= 1'b1;
		smp.x_sample <= xs;
		smp.y_sample <= ys;
		do @(posedge clk); while (!smp.ready);
		p = filter_sample(xs, ys);
		if (typed) begin
			p.x = ex;
			p.y = ey;
		end
		filtered_q.push_back(p);
	endtask

	task automatic run_directed();
		bit pass_x, pass_y;
		pass_x = (cfg_modes[1:0] == MODE_PASS || cfg_modes[1:0] == MODE_PASS3);
		pass_y = (cfg_modes[3:2] == MODE_PASS || cfg_modes[3:2] == MODE_PASS3);
		foreach (directed[i])
			send_sample(directed[i].x, directed[i].y,
				directed[i].typed && pass_x && pass_y, directed[i].ex, directed[i].ey);
	endtask

	// random stick motion: mostly smooth sweeps, with snapbacks and jumps
	task automatic run_random(int n);
		int  kind;
		int  sx, sy;
		logic [15:0] xs, ys;
		sx = 0;
		sy = 0;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (kind < 65) begin
				sx = sx + $signed($urandom_range(2048)) - 1024;
				sy = sy + $signed($urandom_range(2048)) - 1024;
			end else if (kind < 80) begin
				// snapback through the centre
				sx = -sx / 2;
				sy = -sy / 2;
			end else begin
				sx = $signed(16'($urandom));
				sy = $signed(16'($urandom));
			end
			if (sx > 32767) sx = 32767;
			if (sx < -32768) sx = -32768;
			if (sy > 32767) sy = 32767;
			if (sy < -32768) sy = -32768;
			xs = 16'(sx);
			ys = 16'(sy);
			send_sample(xs, ys, 1'b0, 16'h0, 16'h0);
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		// extremes of both fields; in pass mode the sample comes straight back
		directed = '{
			'{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
			'{16'h7fff, 16'h7fff, 1, 16'h7fff, 16'h7fff},
			'{16'h8000, 16'h8000, 1, 16'h8000, 16'h8000},
			'{16'h7fff, 16'h8000, 1, 16'h7fff, 16'h8000},
			'{16'h8000, 16'h7fff, 1, 16'h8000, 16'h7fff},
			'{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
			'{16'hffff, 16'h0001, 1, 16'hffff, 16'h0001},
			'{16'h0100, 16'hff00, 1, 16'h0100, 16'hff00},
			'{16'h5555, 16'haaaa, 1, 16'h5555, 16'haaaa},
			'{16'haaaa, 16'h5555, 1, 16'haaaa, 16'h5555},
			'{16'h6400, 16'h0000, 1, 16'h6400, 16'h0000},
			'{16'h0000, 16'h9c00, 1, 16'h0000, 16'h9c00},
			'{16'h7fff, 16'h0000, 1, 16'h7fff, 16'h0000},
			'{16'h8000, 16'h0000, 1, 16'h8000, 16'h0000},
			'{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
			'{16'h0040, 16'h0040, 1, 16'h0040, 16'h0040},
			'{16'h0080, 16'h0080, 1, 16'h0080, 16'h0080},
			'{16'h7000, 16'h7000, 1, 16'h7000, 16'h7000},
			'{16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
			'{16'hc000, 16'h4000, 1, 16'hc000, 16'h4000}
		};
		cfg_modes = 4'h0;
		cfg_gains[0] = '0;
		cfg_gains[1] = '0;
		cfg_rad_sq = 16'd10000;
		cfg_vgain = '0;
		cfg_again = '0;
		foreach (last_pos[a]) begin
			last_pos[a] = 0;
			last_vel[a] = 0;
			vel_filt[a] = 0;
			last_out[a] = 0;
		end
		mismatches   = 0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		arst_n       = 1'b0;
		write_enable = 1'b0;
		reg_index    = '0;
		write_data   = '0;
		smp.valid    = 1'b0;
		smp.x_sample = '0;
		smp.y_sample = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting is pass-through on both axes
		run_directed();

		// predictive on both axes, moderate gains
		configure({MODE_PRED, MODE_PRED}, 48'h2000_4000_1000, 48'h8000_0800_f000,
			16'd10000, 24'd40000, 24'd20000);
		run_directed();
		run_random(60);
		hold_req = 1'b1;          // long receiver hold-off while samples keep coming
		run_random(60);

		// low-pass, every gain and threshold at its top value
		configure({MODE_LP, MODE_LP}, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
			16'hffff, 24'hffffff, 24'hffffff);
		run_directed();
		run_random(80);

		// x predictive, y low-pass, zero gains and zero radius register
		configure({MODE_LP, MODE_PRED}, 48'h0, 48'h0, 16'd0, 24'd0, 24'd0);
		run_random(60);
		// sender pause until the block has drained
		@(negedge clk);
		smp.valid <= 1'b0;
		wait (filtered_q.size() == 0);
		run_random(50);

		// mode 3 on x, predictive on y, no random idling at all
		quiet = 1'b1;
		configure({MODE_PRED, MODE_PASS3}, $urandom(), {$urandom(), $urandom()},
			16'd1, 24'd1, 24'hffffff);
		run_random(90);
		quiet = 1'b0;

		// random settings
		for (int ph = 0; ph < 3; ph++) begin
			configure(4'($urandom), {$urandom(), $urandom()}, {$urandom(), $urandom()},
				16'($urandom), 24'($urandom), 24'($urandom));
			run_random(70);
		end

		@(negedge clk);
		smp.valid <= 1'b0;
		wait (filtered_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
